@@ hw/rtl/sfcc_pkg.sv @@
// Shared constants and the CRC-8 byte step for the sensor frame checker.
// Used by sensor_frame_crc_and_convert. It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sfcc_pkg;

  // Frame kinds carried on the input tuser
  localparam logic CMD_TEMP = 1'b0;
  localparam logic CMD_RH   = 1'b1;

  // CRC-8, x^8 + x^5 + x^4 + 1, init 0, MSB first
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Conversion gains (raw * gain / 65536) and offsets, in hundredths
  localparam logic [14:0] TEMP_GAIN = 15'd17572;
  localparam logic [14:0] RH_GAIN   = 15'd12500;
  localparam logic [15:0] TEMP_OFS  = 16'd4685;
  localparam logic [15:0] RH_OFS    = 16'd600;

  // Last temperature after reset: 25.00 degC
  localparam logic signed [14:0] TEMP_REF = 15'sd2500;

  // Compensation floor((t - 2500) * 3 / 20) is taken as
  // floor((3t + 14060) / 20) - 1078, which keeps the dividend positive.
  // The divide by 20 is a shift by 2 and a reciprocal multiply for 5.
  localparam logic signed [17:0] COMP_BIAS = 18'sd14060;
  localparam logic signed [15:0] COMP_UNBIAS = 16'sd1078;
  localparam logic [15:0] RECIP5 = 16'd52429;   // ceil(2^18 / 5)
  localparam int RECIP5_SHIFT = 18;

  // Run one data byte through the CRC register
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sensor_frame_crc_and_convert.sv @@
// Top level: CRC check and fixed-point conversion of sensor replies.
// Depends on sfcc_pkg for constants and the CRC byte step.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+----------------------------------------------
//  s_*     | in  | s_tvalid/s_tready | tdata: raw_value, crc_byte; tuser: command
//  m_*     | out | m_tvalid/m_tready | tdata: crc_ok, measured_value, comp. humidity
//
// One transaction per cycle while m_tready is high. An input passes stage 1 and
// stage 2 before the output register raises m_tvalid. Stage 1 holds the frame,
// stage 2 the gain product and high-byte CRC, the output register the result.
// The last temperature is updated as a result enters the output register, so
// a humidity frame right after a temperature frame sees the new value.
// rst clears all valid bits and sets the last temperature to 25.00 degC.
// A stall on m_tready backs up through the stages; empty stages still fill.
`timescale 1ns / 1ps
`default_nettype none
module sensor_frame_crc_and_convert (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [15:0] raw_value, [23:16] crc_byte
  input  wire logic [0:0]  s_tuser,   // [0] command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // [0] crc_ok, [15:1] measured_value,
                                      // [30:16] compensated_humidity, [31] zero
);
  import sfcc_pkg::*;

  // Stage 1: input frame
  logic        v1;
  logic        cmd1;
  logic [15:0] raw1;
  logic [7:0]  chk1;

  // Stage 2: product and partial CRC
  logic        v2;
  logic        cmd2;
  logic [30:0] prod2;
  logic [7:0]  crc_hi2;
  logic [7:0]  lo2;
  logic [7:0]  chk2;

  // Output register and state
  logic        ok_o;
  logic [14:0] meas_o;
  logic [14:0] comp_o;
  logic signed [14:0] last_temp;

  logic en_out, en2, en1;

  // Advance a stage when the one after it can take its contents
  assign en_out   = !m_tvalid || m_tready;
  assign en2      = !v2 || en_out;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && s_tvalid) begin
      cmd1 <= s_tuser[0];
      raw1 <= s_tdata[15:0];
      chk1 <= s_tdata[23:16];
    end
  end

  // Stage 1 -> 2: gain multiply and CRC over the high byte
  logic [14:0] gain1;
  logic [30:0] prod1;
  always_comb begin
    gain1 = (cmd1 == CMD_RH) ? RH_GAIN : TEMP_GAIN;
    prod1 = raw1 * gain1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      cmd2    <= cmd1;
      prod2   <= prod1;
      crc_hi2 <= crc8_byte(8'h00, raw1[15:8]);
      lo2     <= raw1[7:0];
      chk2    <= chk1;
    end
  end

  // Stage 2 -> output: finish CRC, scale, compensate
  logic               ok2;
  logic signed [15:0] meas_full;
  logic signed [17:0] lt_ext;
  logic signed [17:0] comp_num;
  logic [13:0]        quarter;
  logic [29:0]        qprod;
  logic [11:0]        q20;
  logic signed [15:0] comp_off;
  logic signed [15:0] comp_full;

  always_comb begin
    ok2       = (crc8_byte(crc_hi2, lo2) == chk2);
    meas_full = $signed({1'b0, prod2[30:16]})
              - $signed((cmd2 == CMD_RH) ? RH_OFS : TEMP_OFS);
    // floor((3t + 14060) / 20), dividend stays in 5..52718
    lt_ext    = 18'(last_temp);
    comp_num  = (lt_ext <<< 1) + lt_ext + COMP_BIAS;
    quarter   = comp_num[15:2];
    qprod     = quarter * RECIP5;
    q20       = qprod[29:RECIP5_SHIFT];
    comp_off  = $signed({4'b0000, q20}) - COMP_UNBIAS;
    comp_full = meas_full + comp_off;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_out) begin
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && v2) begin
      ok_o   <= ok2;
      meas_o <= ok2 ? meas_full[14:0] : 15'd0;
      comp_o <= (ok2 && cmd2 == CMD_RH) ? comp_full[14:0] : 15'd0;
    end
  end

  // Keep the last good temperature
  always_ff @(posedge clk) begin
    if (rst) begin
      last_temp <= TEMP_REF;
    end else if (en_out && v2 && ok2 && cmd2 == CMD_TEMP) begin
      last_temp <= meas_full[14:0];
    end
  end

  assign m_tdata = {1'b0, comp_o, meas_o, ok_o};

endmodule
`default_nettype wire
